[sv/wsd_pkg.sv]
// shared constants, state encoding and control structs of the welford std dev block
package wsd_pkg;

  // default widths of the top level
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COUNT_BITS_DEF     = 24;
  localparam int MEAN_FRAC_BITS_DEF = 16;

  // fixed widths of the accumulator and the result word
  localparam int M2_W          = 64;
  localparam int M2_FRAC_BITS  = 8;
  localparam int SD_W          = 24;
  localparam int CNT_OUT_W     = 24;
  localparam int STATUS_W      = 2;
  localparam int OUT_DATA_W    = SD_W + CNT_OUT_W;
  localparam int RAD_W         = M2_W + M2_FRAC_BITS;
  localparam int RT_W          = RAD_W / 2;
  localparam int DIV_IT_W      = $clog2(M2_W + 1);
  localparam int MIN_COUNT     = 2;
  localparam int MUL_STEPS     = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_DIV,
    S_MEAN,
    S_D2,
    S_MUL,
    S_ACC,
    S_CHK,
    S_VDIV,
    S_SQRT,
    S_FIN
  } wsd_state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic cnt_step;
    logic sat_set;
    logic mean_upd;
    logic d2_calc;
    logic mul_step;
    logic m2_add;
    logic vdiv_start;
    logic sqrt_start;
    logic out_load;
    logic clear;
  } wsd_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic cnt_full;
    logic last;
    logic sat;
    logic few;
    logic div_busy;
    logic sqrt_busy;
    logic mul_done;
    logic out_free;
  } wsd_sts_t;

endpackage

[sv/wsd_div.sv]
// iterative restoring divider, one quotient bit per cycle
module wsd_div #(
  parameter int DVD_W = wsd_pkg::M2_W,
  parameter int DVS_W = wsd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [DVS_W-1:0]              divisor,
  input  logic [wsd_pkg::DIV_IT_W-1:0]  iters,
  output logic                          busy,
  output logic [DVD_W-1:0]              quotient
);
  import wsd_pkg::*;

  logic [DIV_IT_W-1:0] it_r, it_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W:0]      shifted;
  logic [DVS_W:0]      diff;
  logic                ge;

  // one restoring step
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    it_nxt  = it_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    if (start) begin
      it_nxt  = iters;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (it_r != '0) begin
      it_nxt  = it_r - DIV_IT_W'(1);
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else begin
      it_r <= it_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = (it_r != '0);
  assign quotient = dvd_r;

endmodule

[sv/wsd_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
module wsd_sqrt #(
  parameter int RAD_W = wsd_pkg::RAD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               busy,
  output logic [RAD_W/2-1:0] root
);
  import wsd_pkg::*;

  localparam int R_W  = RAD_W / 2;
  localparam int IT_W = $clog2(R_W + 1);

  logic [IT_W-1:0]  it_r, it_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [R_W-1:0]   root_r, root_nxt;
  logic [R_W+1:0]   rem_r, rem_nxt;
  logic [R_W+3:0]   shifted;
  logic [R_W+3:0]   trial;
  logic [R_W+3:0]   diff;
  logic             ge;

  // bring down two radicand bits and try the next root bit
  assign shifted = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  always_comb begin
    it_nxt   = it_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (start) begin
      it_nxt   = IT_W'(R_W);
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (it_r != '0) begin
      it_nxt   = it_r - IT_W'(1);
      rad_nxt  = rad_r << 2;
      root_nxt = {root_r[R_W-2:0], ge};
      rem_nxt  = ge ? diff[R_W+1:0] : shifted[R_W+1:0];
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else begin
      it_r <= it_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy = (it_r != '0);
  assign root = root_r;

endmodule

[sv/wsd_datapath.sv]
// datapath: running statistics, shared divider, multiplier steps, root and result register
module wsd_datapath #(
  parameter int SAMPLE_BITS    = wsd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS     = wsd_pkg::COUNT_BITS_DEF,
  parameter int MEAN_FRAC_BITS = wsd_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  input  logic                            in_last,
  input  wsd_pkg::wsd_cmd_t               cmd,
  output wsd_pkg::wsd_sts_t               sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wsd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [wsd_pkg::STATUS_W-1:0]    out_tuser
);
  import wsd_pkg::*;

  localparam int XW   = SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int MW   = XW + 1;
  localparam int DW   = XW + 2;
  localparam int HW   = (XW + 1) / 2;
  localparam int PW   = 4 * HW;
  localparam int SH   = 2 * MEAN_FRAC_BITS - M2_FRAC_BITS;
  localparam int PSW  = PW - SH;
  localparam int EXW  = (PSW > M2_W) ? PSW : M2_W;
  localparam int CE_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

  // running statistics
  logic [MW-1:0]         mean_r, mean_nxt;
  logic [M2_W-1:0]       m2_r, m2_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  sat_r, sat_nxt;

  // per-sample working registers
  logic [XW-1:0]         x_r;
  logic                  last_r;
  logic [XW-1:0]         mag_r;
  logic                  neg_r;
  logic [XW-1:0]         mag2_r;
  logic [2*HW-1:0]       pp_r;
  logic [1:0]            pp_sh_r;
  logic [PW-1:0]         acc_r;
  logic [2:0]            pp_idx_r, pp_idx_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [SD_W-1:0]       out_sd_r;
  logic [CNT_OUT_W-1:0]  out_cnt_r;
  logic [STATUS_W-1:0]   out_status_r;

  // deviation from the mean before the update
  logic [DW-1:0] d1, d1_abs;
  logic [XW-1:0] mag_nxt;
  assign d1      = {{2{x_r[XW-1]}}, x_r} - {mean_r[MW-1], mean_r};
  assign d1_abs  = d1[DW-1] ? (~d1 + DW'(1)) : d1;
  assign mag_nxt = d1_abs[XW-1:0];

  // deviation from the mean after the update
  logic [DW-1:0] d2, d2_abs;
  assign d2     = {{2{x_r[XW-1]}}, x_r} - {mean_r[MW-1], mean_r};
  assign d2_abs = d2[DW-1] ? (~d2 + DW'(1)) : d2;

  // shared divider: mean step, then the variance on the last word
  logic                  div_start, div_busy;
  logic [M2_W-1:0]       div_dvd, div_q;
  logic [COUNT_BITS-1:0] div_dvs;
  logic [DIV_IT_W-1:0]   div_its;

  assign div_start = cmd.cnt_step | cmd.vdiv_start;
  assign div_dvd   = cmd.cnt_step ? (M2_W'(mag_nxt) << (M2_W - XW)) : m2_r;
  assign div_dvs   = cmd.cnt_step ? (cnt_r + COUNT_BITS'(1)) : (cnt_r - COUNT_BITS'(1));
  assign div_its   = cmd.cnt_step ? DIV_IT_W'(XW) : DIV_IT_W'(M2_W);

  wsd_div #(
    .DVD_W (M2_W),
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_its),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // square root of the variance scaled to Q.8 output
  logic            sqrt_busy;
  logic [RT_W-1:0] root;

  wsd_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand ({div_q, {M2_FRAC_BITS{1'b0}}}),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // mean step, truncated toward zero
  logic [MW-1:0] q_ext;
  assign q_ext = {1'b0, div_q[XW-1:0]};

  // partial product selection, one half by half per multiply step
  logic [2*HW-1:0] a_pad, b_pad;
  logic [HW-1:0]   a_sel, b_sel;
  logic [2*HW-1:0] pp_nxt;
  logic [PW-1:0]   pp_ext, pp_shifted;
  assign a_pad  = (2*HW)'(mag_r);
  assign b_pad  = (2*HW)'(mag2_r);
  assign a_sel  = pp_idx_r[1] ? a_pad[2*HW-1:HW] : a_pad[HW-1:0];
  assign b_sel  = pp_idx_r[0] ? b_pad[2*HW-1:HW] : b_pad[HW-1:0];
  assign pp_nxt = a_sel * b_sel;
  assign pp_ext = PW'(pp_r);

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << HW;
      default: pp_shifted = pp_ext << (2 * HW);
    endcase
  end

  // scaled product into the saturating accumulator
  logic [EXW-1:0]  p_ext;
  logic            p_hi;
  logic [M2_W:0]   m2_sum;
  assign p_ext  = EXW'(acc_r >> SH);
  assign p_hi   = (p_ext >> M2_W) != '0;
  assign m2_sum = {1'b0, m2_r} + {1'b0, p_ext[M2_W-1:0]};

  // result fields
  logic                 few;
  logic [STATUS_W-1:0]  status_sel;
  logic [SD_W-1:0]      sd_sat;
  logic [CE_W-1:0]      cnt_ext;
  logic [CNT_OUT_W-1:0] cnt_out;
  assign few        = cnt_r < COUNT_BITS'(MIN_COUNT);
  assign status_sel = sat_r ? STATUS_SAT : (few ? STATUS_FEW : STATUS_OK);
  assign sd_sat     = (root > RT_W'({SD_W{1'b1}})) ? {SD_W{1'b1}} : root[SD_W-1:0];
  assign cnt_ext    = CE_W'(cnt_r);
  assign cnt_out    = (cnt_ext > CE_W'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                           : cnt_ext[CNT_OUT_W-1:0];

  // next values of the statistics and control registers
  always_comb begin
    mean_nxt      = mean_r;
    m2_nxt        = m2_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    pp_idx_nxt    = pp_idx_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.cnt_step) begin
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
    if (cmd.sat_set) begin
      sat_nxt = 1'b1;
    end
    if (cmd.mean_upd) begin
      mean_nxt = neg_r ? (mean_r - q_ext) : (mean_r + q_ext);
    end
    if (cmd.d2_calc) begin
      pp_idx_nxt = '0;
    end
    if (cmd.mul_step) begin
      pp_idx_nxt = pp_idx_r + 3'd1;
    end
    if (cmd.m2_add) begin
      if (p_hi || m2_sum[M2_W]) begin
        m2_nxt  = '1;
        sat_nxt = 1'b1;
      end else begin
        m2_nxt = m2_sum[M2_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.clear) begin
      mean_nxt = '0;
      m2_nxt   = '0;
      cnt_nxt  = '0;
      sat_nxt  = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r      <= '0;
      m2_r        <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      pp_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mean_r      <= mean_nxt;
      m2_r        <= m2_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      pp_idx_r    <= pp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers of one word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= {in_sample, {MEAN_FRAC_BITS{1'b0}}};
      last_r <= in_last;
    end
    if (cmd.cnt_step) begin
      mag_r <= mag_nxt;
      neg_r <= d1[DW-1];
    end
    if (cmd.d2_calc) begin
      mag2_r <= d2_abs[XW-1:0];
      acc_r  <= '0;
    end
    if (cmd.mul_step) begin
      if (pp_idx_r != 3'(MUL_STEPS)) begin
        pp_r    <= pp_nxt;
        pp_sh_r <= {1'b0, pp_idx_r[1]} + {1'b0, pp_idx_r[0]};
      end
      if (pp_idx_r != '0) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
    if (cmd.out_load) begin
      out_sd_r     <= (status_sel == STATUS_OK) ? sd_sat : '0;
      out_cnt_r    <= cnt_out;
      out_status_r <= status_sel;
    end
  end

  // status to the sequencer
  always_comb begin
    sts.cnt_full  = &cnt_r;
    sts.last      = last_r;
    sts.sat       = sat_r;
    sts.few       = few;
    sts.div_busy  = div_busy;
    sts.sqrt_busy = sqrt_busy;
    sts.mul_done  = (pp_idx_r == 3'(MUL_STEPS));
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_sd_r};
  assign out_tuser  = out_status_r;

  // count only steps up by one or clears
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + COUNT_BITS'(1)) || (cnt_r == '0)))
    else $error("sample count jumped");

  // accumulator never shrinks within a sequence
  a_m2_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.clear)) |-> (m2_r >= $past(m2_r)))
    else $error("squared deviation sum decreased");

  // statistics are empty after a result is issued
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> ((cnt_r == '0) && (m2_r == '0) && !sat_r && (mean_r == '0)))
    else $error("statistics not cleared after result");

endmodule

[sv/wsd_ctrl.sv]
// sequencer that steps one sample through update and result
module wsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  wsd_pkg::wsd_sts_t  sts,
  output wsd_pkg::wsd_cmd_t  cmd
);
  import wsd_pkg::*;

  wsd_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CNT;
      S_CNT:  state_nxt = sts.cnt_full ? S_CHK : S_DIV;
      S_DIV:  if (!sts.div_busy) state_nxt = S_MEAN;
      S_MEAN: state_nxt = S_D2;
      S_D2:   state_nxt = S_MUL;
      S_MUL:  if (sts.mul_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = S_CHK;
      S_CHK: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.sat || sts.few) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_VDIV;
        end
      end
      S_VDIV: if (!sts.div_busy) state_nxt = S_SQRT;
      S_SQRT: if (!sts.sqrt_busy) state_nxt = S_FIN;
      S_FIN:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_CNT: begin
        cmd.sat_set  = sts.cnt_full;
        cmd.cnt_step = !sts.cnt_full;
      end
      S_MEAN: cmd.mean_upd = 1'b1;
      S_D2:   cmd.d2_calc  = 1'b1;
      S_MUL:  cmd.mul_step = 1'b1;
      S_ACC:  cmd.m2_add   = 1'b1;
      S_CHK:  cmd.vdiv_start = sts.last && !sts.sat && !sts.few;
      S_VDIV: cmd.sqrt_start = !sts.div_busy;
      S_FIN: begin
        cmd.out_load = sts.out_free;
        cmd.clear    = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a started divide keeps the divider busy
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_step || cmd.vdiv_start) |=> sts.div_busy)
    else $error("divider did not start");

  // a started root keeps the root unit busy
  a_sqrt_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |=> sts.sqrt_busy)
    else $error("square root did not start");

endmodule

[sv/welford_std_dev_stream.sv]
// the time of each sample is set by the mean divide
// a last sample with a valid result then runs a 64-step variance divide
// on the same divider, then a 36-step square root, then the result register
// a new sample is accepted while a finished result still waits in the output register
// rst_n is synchronous, active low; it clears count, mean, accumulator and output valid
// top level: sample standard deviation of a sample stream by the online update
module welford_std_dev_stream #(
  parameter int SAMPLE_BITS    = wsd_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS     = wsd_pkg::COUNT_BITS_DEF,
  parameter int MEAN_FRAC_BITS = wsd_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wsd_pkg::OUT_DATA_W-1:0]      out_tdata,  // std_dev, sample_count
  output logic [wsd_pkg::STATUS_W-1:0]        out_tuser   // status
);
  import wsd_pkg::*;

  wsd_cmd_t cmd;
  wsd_sts_t sts;

  // sequencer
  wsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath with result register
  wsd_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COUNT_BITS     (COUNT_BITS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[test/tb.sv]
// testbench for the welford std dev stream block: directed and random sequences checked against a local model
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int TOTAL_RAND = 1400;
  localparam int DRAIN_CYC  = 300;
  localparam int PROD_SHIFT = 2 * MEAN_FRAC_BITS_DEF - M2_FRAC_BITS;

  // one pending input word and one expected result word
  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] sample;
    logic                              last;
  } sample_word_t;

  typedef struct packed {
    logic [SD_W-1:0]      std_dev;
    logic [CNT_OUT_W-1:0] count;
    logic [STATUS_W-1:0]  status;
  } std_result_t;

  // content styles of a random sequence
  typedef enum int {
    SEQ_FULL,
    SEQ_NEAR,
    SEQ_FLAT,
    SEQ_SWING
  } seq_kind_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [SAMPLE_BITS_DEF-1:0]  in_tdata = '0;   // sample
  logic                        in_tlast = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]       out_tdata;       // std_dev, sample_count
  logic [STATUS_W-1:0]         out_tuser;       // status

  sample_word_t sample_q[$];
  std_result_t  result_q[$];
  int           total_words;
  int           taken_cnt = 0;
  int           miss_cnt = 0;
  logic         in_fire = 1'b0;

  // local copy of the running statistics
  logic signed [63:0]    mean_acc = '0;
  logic [63:0]           m2_acc = '0;
  logic [COUNT_BITS_DEF-1:0] cnt_acc = '0;
  logic                  sat_acc = 1'b0;

  // sender and receiver pacing
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int rx_cyc = 0;

  welford_std_dev_stream u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // floor of sqrt(v * 256), clamped to the result width
  function automatic logic [SD_W-1:0] sqrt_q8(input logic [63:0] v);
    logic [71:0] rad;
    logic [71:0] sq;
    logic [35:0] r;
    logic [35:0] t;
    rad = {v, 8'h00};
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      sq = 72'(t) * 72'(t);
      if (sq <= rad) r = t;
    end
    if (r > 36'hFFFFFF) return '1;
    return r[SD_W-1:0];
  endfunction

  // one online update of count, mean and squared deviation sum
  task automatic welford_add(input logic signed [SAMPLE_BITS_DEF-1:0] x);
    logic signed [63:0] xf;
    logic signed [63:0] d1;
    logic signed [63:0] d2;
    logic [63:0]        n;
    logic [63:0]        mag1;
    logic [63:0]        mag2;
    logic [63:0]        q;
    logic [127:0]       prod;
    logic [64:0]        sum;
    if (cnt_acc == '1) begin
      sat_acc = 1'b1;
      return;
    end
    cnt_acc = cnt_acc + COUNT_BITS_DEF'(1);
    n = 64'(cnt_acc);
    xf = 64'(x);
    xf = xf <<< MEAN_FRAC_BITS_DEF;
    d1 = xf - mean_acc;
    mag1 = (d1 < 0) ? -d1 : d1;
    q = mag1 / n;
    // division truncates toward zero on the magnitude
    if (d1 < 0) mean_acc = mean_acc - $signed(q);
    else mean_acc = mean_acc + $signed(q);
    d2 = xf - mean_acc;
    mag2 = (d2 < 0) ? -d2 : d2;
    prod = {64'd0, mag1} * {64'd0, mag2};
    prod = prod >> PROD_SHIFT;
    if (prod[127:64] != '0) begin
      m2_acc = '1;
      sat_acc = 1'b1;
      return;
    end
    sum = {1'b0, m2_acc} + {1'b0, prod[63:0]};
    if (sum[64]) begin
      m2_acc = '1;
      sat_acc = 1'b1;
    end else begin
      m2_acc = sum[63:0];
    end
  endtask

  // expected result of a finished sequence, then clear the statistics
  task automatic finish_sequence();
    std_result_t res;
    res.std_dev = '0;
    res.count = cnt_acc;
    if (sat_acc) begin
      res.status = STATUS_SAT;
    end else if (cnt_acc < MIN_COUNT) begin
      res.status = STATUS_FEW;
    end else begin
      res.status = STATUS_OK;
      res.std_dev = sqrt_q8(m2_acc / (64'(cnt_acc) - 1));
    end
    result_q.push_back(res);
    mean_acc = '0;
    m2_acc = '0;
    cnt_acc = '0;
    sat_acc = 1'b0;
  endtask

  // random sequence with content of the given style
  task automatic queue_sequence(input int len, input seq_kind_t kind);
    sample_word_t w;
    logic signed [SAMPLE_BITS_DEF-1:0] base;
    int spread;
    base = 16'($urandom);
    spread = 1 << $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_FULL: begin
          w.sample = 16'($urandom);
        end
        SEQ_NEAR: begin
          w.sample = base + $signed(16'($urandom_range(0, 2 * spread))) - 16'(spread);
        end
        SEQ_FLAT: begin
          w.sample = base;
        end
        default: begin
          w.sample = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        end
      endcase
      w.last = (i == len - 1);
      sample_q.push_back(w);
    end
  endtask

  task automatic queue_word(input logic signed [SAMPLE_BITS_DEF-1:0] s, input logic l);
    sample_word_t w;
    w.sample = s;
    w.last = l;
    sample_q.push_back(w);
  endtask

  task automatic note_miss(input string msg);
    miss_cnt++;
    if (miss_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // sender: bursts of words with random gaps, changing only on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample_word_t w;
        w = sample_q.pop_front();
        in_tdata <= w.sample;
        in_tlast <= w.last;
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, with calm stretches where it never stalls
  always @(negedge clk) begin
    rx_cyc++;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (((rx_cyc / 4000) % 3 != 0) && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 50);
    end
  end

  // input side: predict on every accepted word
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      taken_cnt++;
      welford_add($signed(in_tdata));
      if (in_tlast) finish_sequence();
    end
  end

  // output side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        note_miss($sformatf("unexpected word sd=%0d cnt=%0d status=%0d",
                            out_tdata[SD_W-1:0], out_tdata[OUT_DATA_W-1:SD_W], out_tuser));
      end else begin
        std_result_t exp_res;
        exp_res = result_q.pop_front();
        if (out_tdata[SD_W-1:0] !== exp_res.std_dev ||
            out_tdata[OUT_DATA_W-1:SD_W] !== exp_res.count ||
            out_tuser !== exp_res.status)
          note_miss($sformatf("exp sd=%0d cnt=%0d status=%0d, got sd=%0d cnt=%0d status=%0d",
                              exp_res.std_dev, exp_res.count, exp_res.status,
                              out_tdata[SD_W-1:0], out_tdata[OUT_DATA_W-1:SD_W], out_tuser));
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int rand_words;
    int len;
    int pick;
    // single samples give the too-few status
    queue_word(16'sh8000, 1'b1);
    queue_word(16'sh7FFF, 1'b1);
    queue_word(16'sh0000, 1'b1);
    // widest swing in both orders
    queue_word(16'sh8000, 1'b0);
    queue_word(16'sh7FFF, 1'b1);
    queue_word(16'sh7FFF, 1'b0);
    queue_word(16'sh8000, 1'b1);
    // constant run gives zero deviation
    for (int i = 0; i < 5; i++) queue_word(16'sd1234, i == 4);
    // negative means exercise truncation toward zero
    queue_word(-16'sd1, 1'b0);
    queue_word(-16'sd2, 1'b0);
    queue_word(-16'sd4, 1'b1);
    queue_word(16'sd1, 1'b0);
    queue_word(16'sd2, 1'b1);
    // alternating extremes
    for (int i = 0; i < 4; i++) queue_word((i % 2) ? 16'sh8000 : 16'sh7FFF, i == 3);

    rand_words = 0;
    while (rand_words < TOTAL_RAND) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 150);
      queue_sequence(len, seq_kind_t'($urandom_range(0, 3)));
      rand_words += len;
    end
    total_words = sample_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < total_words) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (miss_cnt == 0 && result_q.size() == 0) begin
      $display("welford_std_dev_stream: match");
    end else begin
      $display("welford_std_dev_stream: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #30_000_000;
    $display("welford_std_dev_stream: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/wsd_pkg.sv
sv/wsd_div.sv
sv/wsd_sqrt.sv
sv/wsd_datapath.sv
sv/wsd_ctrl.sv
sv/welford_std_dev_stream.sv
test/tb.sv
